// ===== rtl/bitmap_bit_ops_find_next_top_assert.svh =====
// ---------------------------------------------------------------------------
// Bitmap bit-ops assertion macros
// Shared concurrent assertion shorthands for the bitmap bit-ops block.
// ---------------------------------------------------------------------------
`ifndef BITMAP_BIT_OPS_FIND_NEXT_TOP_ASSERT_SVH
`define BITMAP_BIT_OPS_FIND_NEXT_TOP_ASSERT_SVH

// Property checked on the rising edge, ignored while reset is high.
`define BBF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define BBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bbf_pkg.sv =====
// ---------------------------------------------------------------------------
// Bitmap bit-ops package
// Sizes, operation codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package bbf_pkg;

  localparam int BITMAP_BITS = 1024;
  localparam int WORD_BITS   = 64;
  localparam int NUM_WORDS   = BITMAP_BITS / WORD_BITS;
  localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int INDEX_W     = WORD_IDX_W + BIT_IDX_W;
  localparam int SIZE_W      = INDEX_W + 1;
  localparam int KIND_W      = 4;

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(BITMAP_BITS);

  typedef enum logic [KIND_W-1:0] {
    K_SET         = 4'd0,
    K_CLEAR       = 4'd1,
    K_TOGGLE      = 4'd2,
    K_TEST_SET    = 4'd3,
    K_TEST_CLEAR  = 4'd4,
    K_TEST_TOGGLE = 4'd5,
    K_TEST        = 4'd6,
    K_FIND_SET    = 4'd7,
    K_FIND_ZERO   = 4'd8
  } kind_t;

  typedef struct packed {
    logic load_item;    // latch kind and index, point at the addressed word
    logic capture_old;  // keep the addressed bit before any change
    logic do_update;    // write the modified word back
    logic scan_next;    // move the scan to the next word
    logic load_out;     // load the result register
  } bbf_cmd_t;

  typedef struct packed {
    logic is_find;      // latched item is a find
    logic scan_done;    // current word settles the find
  } bbf_status_t;

endpackage

// ===== rtl/bbf_datapath.sv =====
// ---------------------------------------------------------------------------
// Bitmap bit-ops datapath
// Bitmap words, size register, bit update, word-at-a-time scan, result regs.
// ---------------------------------------------------------------------------
module bbf_datapath import bbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [KIND_W-1:0]     kind,
  input  logic [INDEX_W-1:0]    bit_index,
  input  logic                  cfg_wr_en,
  input  logic [SIZE_W-1:0]     cfg_wr_data,
  input  bbf_cmd_t              cmd,
  output bbf_status_t           status,
  output logic                  old_bit,
  output logic [SIZE_W-1:0]     found_index
);

  logic [WORD_BITS-1:0]  bitmap [NUM_WORDS];
  logic [SIZE_W-1:0]     size_q;
  logic [KIND_W-1:0]     kind_q;
  logic [INDEX_W-1:0]    start_q;
  logic [WORD_IDX_W-1:0] ptr;
  logic                  old_q;

  logic [WORD_BITS-1:0]  word_rd;
  logic [WORD_BITS-1:0]  word_new;
  logic [WORD_BITS-1:0]  pos_onehot;
  logic [BIT_IDX_W-1:0]  bit_pos;
  logic                  old_now;
  logic                  is_find;
  logic [SIZE_W-1:0]     limit;
  logic                  start_ge;
  logic [WORD_BITS-1:0]  search;
  logic [WORD_BITS-1:0]  lo_mask;
  logic [WORD_BITS-1:0]  hi_mask;
  logic [WORD_BITS-1:0]  cand;
  logic                  hit;
  logic [BIT_IDX_W-1:0]  hit_pos;
  logic [WORD_IDX_W:0]   ptr_inc;
  logic [WORD_IDX_W:0]   limit_word;
  logic                  last_word;
  logic [SIZE_W-1:0]     found_val;

  assign word_rd    = bitmap[ptr];
  assign bit_pos    = start_q[BIT_IDX_W-1:0];
  assign old_now    = word_rd[bit_pos];
  assign pos_onehot = WORD_BITS'(1) << bit_pos;
  assign is_find    = (kind_q == K_FIND_SET) || (kind_q == K_FIND_ZERO);

  always_comb begin
    case (kind_q)
      K_SET, K_TEST_SET:       word_new = word_rd | pos_onehot;
      K_CLEAR, K_TEST_CLEAR:   word_new = word_rd & ~pos_onehot;
      K_TOGGLE, K_TEST_TOGGLE: word_new = word_rd ^ pos_onehot;
      default:                 word_new = word_rd;
    endcase
  end

  // find: search window is [start, min(size, BITMAP_BITS))
  assign limit      = (size_q > MAX_SIZE) ? MAX_SIZE : size_q;
  assign start_ge   = {1'b0, start_q} >= limit;
  assign search     = (kind_q == K_FIND_SET) ? word_rd : ~word_rd;
  assign limit_word = limit[SIZE_W-1:BIT_IDX_W];

  always_comb begin
    if (ptr == start_q[INDEX_W-1:BIT_IDX_W]) begin
      lo_mask = ~((WORD_BITS'(1) << bit_pos) - WORD_BITS'(1));
    end else begin
      lo_mask = '1;
    end
    if (limit_word > {1'b0, ptr}) begin
      hi_mask = '1;
    end else if (limit_word == {1'b0, ptr}) begin
      hi_mask = (WORD_BITS'(1) << limit[BIT_IDX_W-1:0]) - WORD_BITS'(1);
    end else begin
      hi_mask = '0;
    end
  end

  assign cand = search & lo_mask & hi_mask;
  assign hit  = |cand;

  // lowest set bit of the candidate word
  always_comb begin
    hit_pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_pos = BIT_IDX_W'(j);
      end
    end
  end

  assign ptr_inc   = {1'b0, ptr} + 1'b1;
  assign last_word = {ptr_inc, {BIT_IDX_W{1'b0}}} >= limit;
  assign found_val = (start_ge || !hit) ? limit : {1'b0, ptr, hit_pos};

  assign status.is_find   = is_find;
  assign status.scan_done = start_ge || hit || last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        bitmap[w] <= '0;
      end
      size_q <= MAX_SIZE;
    end else begin
      if (cmd.do_update) begin
        bitmap[ptr] <= word_new;
      end
      if (cfg_wr_en) begin
        size_q <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_q  <= kind;
      start_q <= bit_index;
      ptr     <= bit_index[INDEX_W-1:BIT_IDX_W];
    end else if (cmd.scan_next) begin
      ptr <= ptr + 1'b1;
    end
    if (cmd.capture_old) begin
      old_q <= old_now;
    end
    if (cmd.load_out) begin
      old_bit     <= is_find ? old_q : old_now;
      found_index <= is_find ? found_val : '0;
    end
  end

endmodule

// ===== rtl/bbf_ctrl.sv =====
// ---------------------------------------------------------------------------
// Bitmap bit-ops controller
// Sequences accept, bit update or word scan, and the result transfer.
// ---------------------------------------------------------------------------
`include "bitmap_bit_ops_find_next_top_assert.svh"

module bbf_ctrl import bbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  bbf_status_t status,
  output bbf_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.capture_old = 1'b1;
        if (status.is_find) begin
          state_next = S_SCAN;
        end else if (out_free) begin
          cmd.do_update = 1'b1;
          cmd.load_out  = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BBF_ASSERT(a_accept_to_exec, clk, rst, in_valid && in_ready |=> state == S_EXEC, "accept did not enter exec")
  `BBF_ASSERT(a_result_source, clk, rst, $rose(out_valid) |-> $past(state == S_EXEC) || $past(state == S_SCAN), "result without an item")
  `BBF_ASSERT(a_scan_holds, clk, rst, state == S_SCAN && !status.scan_done |=> state == S_SCAN, "scan left early")

endmodule

// ===== rtl/bitmap_bit_ops_find_next_top.sv =====
// ---------------------------------------------------------------------------
// Bitmap bit operations with find-next
// Top level: 1024-bit bitmap with set/clear/toggle/test and find-next.
// ---------------------------------------------------------------------------
// A 1024-bit bitmap, cleared by reset, held as sixteen 64-bit words. Each
// input transfer carries an operation (kind) and a bit index; each gives
// exactly one output transfer with the old value of the addressed bit and,
// for find-next-set / find-next-zero, the first matching index from the
// start index up to min(bitmap_size, 1024), or that limit when nothing
// matches (found_index is zero for other kinds; unused kinds act as test).
// One item is handled at a time. A bit operation finishes in the exec
// state; a find goes on to the scan state, which reads one bitmap word
// per cycle through the single word port, from the start word up to the
// last word below the limit. A result waiting in the output register
// holds back the next result, not the next input transfer. bitmap_size
// may be written through cfg_wr_en/cfg_wr_data only while the block is idle.
// ---------------------------------------------------------------------------
module bitmap_bit_ops_find_next_top import bbf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // item in
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [INDEX_W-1:0] bit_index,
  // result out
  output logic               out_valid,
  input  logic               out_ready,
  output logic               old_bit,
  output logic [SIZE_W-1:0]  found_index,
  // bitmap_size register
  input  logic               cfg_wr_en,
  input  logic [SIZE_W-1:0]  cfg_wr_data
);

  bbf_cmd_t    cmd;
  bbf_status_t status;

  // sequencing: accept, then update or scan, then result transfer
  bbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // storage, size register and search logic
  bbf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .kind        (kind),
    .bit_index   (bit_index),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .old_bit     (old_bit),
    .found_index (found_index)
  );

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// Bitmap bit-ops testbench
// Self-checking bench for the bitmap bit operations and find-next block.
// ---------------------------------------------------------------------------
// The bench keeps its own copy of the 1024-bit bitmap and of bitmap_size.
// Each input transfer is applied to that copy, and the result it should
// give is queued. Each output transfer is checked against the oldest queued
// result. bitmap_size is changed only while the block is drained. Directed
// items come first, then phases of random items, each under its own size
// and idling pattern.
// ---------------------------------------------------------------------------
module tb_top import bbf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 3000;  // cycles with no transfer on either side
  localparam int SETTLE_CYCLES = 24;    // longer than the slowest find
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int PHASE_ITEMS   = 140;
  localparam int NUM_PHASES    = 11;

  typedef struct {
    logic [KIND_W-1:0]  op;
    logic [INDEX_W-1:0] idx;
  } bit_op_t;

  typedef struct {
    bit              old;
    bit [SIZE_W-1:0] found;
  } bit_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KIND_W-1:0]  kind = '0;
  logic [INDEX_W-1:0] bit_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               old_bit;
  logic [SIZE_W-1:0]  found_index;
  logic               cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0]  cfg_wr_data = '0;

  // Bench's own copy of the block state
  bit [BITMAP_BITS-1:0] bm_bits  = '0;
  bit [SIZE_W-1:0]      bm_limit = MAX_SIZE;

  bit_op_t     pending_ops[$];
  bit_result_t expected_results[$];

  int unsigned pushed_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned result_cnt   = 0;
  int unsigned err_cnt      = 0;
  int unsigned quiet_cycles = 0;

  // Transfer flags from the last rising edge, read by the falling-edge drivers
  bit in_took  = 1'b0;
  bit out_took = 1'b0;

  // Idling knobs, set per phase
  int unsigned send_gap_max = 0;
  int unsigned recv_gap_max = 0;
  int unsigned hold_asks    = 0;

  bitmap_bit_ops_find_next_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .bit_index   (bit_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .old_bit     (old_bit),
    .found_index (found_index),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // First index from start below min(size, BITMAP_BITS) whose bit equals
  // want; that limit when nothing matches. A size of zero searches nothing.
  function automatic logic [SIZE_W-1:0] scan_from(input logic [INDEX_W-1:0] start,
                                                  input bit want);
    int lim;
    lim = (bm_limit > BITMAP_BITS) ? BITMAP_BITS : int'(bm_limit);
    for (int i = int'(start); i < lim; i++) begin
      if (bm_bits[i] == want) return SIZE_W'(i);
    end
    return SIZE_W'(lim);
  endfunction

  // Applies one operation to the bitmap copy and gives the result it causes.
  // Unused kinds fall to the default arm and behave as a plain test.
  function automatic bit_result_t apply_op(input logic [KIND_W-1:0] op,
                                           input logic [INDEX_W-1:0] idx);
    bit_result_t res;
    res.old   = bm_bits[idx];
    res.found = '0;
    case (op)
      K_SET, K_TEST_SET:       bm_bits[idx] = 1'b1;
      K_CLEAR, K_TEST_CLEAR:   bm_bits[idx] = 1'b0;
      K_TOGGLE, K_TEST_TOGGLE: bm_bits[idx] = ~bm_bits[idx];
      K_FIND_SET:              res.found = scan_from(idx, 1'b1);
      K_FIND_ZERO:             res.found = scan_from(idx, 1'b0);
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got_v,
                               input int unsigned exp_v);
    $display("%0t: result %0d %s: got %0d, expected %0d",
             $time, result_cnt, what, got_v, exp_v);
    err_cnt++;
  endtask

  // -------------------------------------------------------------------------
  // Monitor: checks output transfers, predicts on input transfers.
  // The check runs first, as a result can never belong to an item taken at
  // the same edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    bit_result_t want;
    in_took  <= !rst && in_valid && in_ready;
    out_took <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("arrived with none outstanding", found_index, 0);
      end else begin
        want = expected_results.pop_front();
        if (old_bit !== want.old)
          flag_mismatch("old_bit", old_bit, want.old);
        if (found_index !== want.found)
          flag_mismatch("found_index", found_index, want.found);
      end
      result_cnt++;
    end
    if (!rst && in_valid && in_ready) begin
      expected_results.push_back(apply_op(kind, bit_index));
      accepted_cnt++;
    end
  end

  // -------------------------------------------------------------------------
  // Driver: one item per transfer, random gap after each transfer
  // -------------------------------------------------------------------------
  int unsigned send_wait = 0;

  always @(negedge clk) begin
    bit_op_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        nxt = pending_ops.pop_front();
        in_valid  <= 1'b1;
        kind      <= nxt.op;
        bit_index <= nxt.idx;
        send_wait = $urandom_range(0, send_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random stall per result, plus the occasional long hold-off
  // -------------------------------------------------------------------------
  int unsigned recv_wait   = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_served = 0;

  always @(negedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left   = HOLD_CYCLES;
    end
    if (out_took) recv_wait = $urandom_range(0, recv_gap_max);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: too long with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  task automatic queue_op(input logic [KIND_W-1:0] op, input logic [INDEX_W-1:0] idx);
    bit_op_t item;
    item.op  = op;
    item.idx = idx;
    pending_ops.push_back(item);
    pushed_cnt++;
  endtask

  // Returns at a falling edge once every item is taken and every result is
  // in, after a margin for anything still in flight.
  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_cnt != pushed_cnt || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Called at a falling edge with the block drained
  task automatic write_size(input logic [SIZE_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    bm_limit = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Random items; one pick in four is a run: one operation over a stretch of
  // consecutive bits (wrapping at the top), then finds from either end of
  // the stretch, so that scans cross several words.
  task automatic queue_random_phase(input int n_items);
    int done_cnt, base, len, lim, r;
    logic [KIND_W-1:0]  op;
    logic [INDEX_W-1:0] idx;
    done_cnt = 0;
    lim = (bm_limit > BITMAP_BITS) ? BITMAP_BITS : int'(bm_limit);
    while (done_cnt < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        base = $urandom_range(0, BITMAP_BITS - 1);
        len  = $urandom_range(1, 130);
        op   = KIND_W'($urandom_range(K_SET, K_TEST_TOGGLE));
        for (int j = 0; j < len; j++) queue_op(op, INDEX_W'(base + j));
        queue_op(K_FIND_ZERO, INDEX_W'(base));
        queue_op(K_FIND_SET, INDEX_W'(base));
        queue_op($urandom_range(0, 1) ? K_FIND_SET : K_FIND_ZERO, INDEX_W'(base + len));
        done_cnt += len + 3;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50)      op = KIND_W'($urandom_range(K_SET, K_TEST_TOGGLE));
        else if (r < 80) op = $urandom_range(0, 1) ? K_FIND_SET : K_FIND_ZERO;
        else if (r < 92) op = K_TEST;
        else             op = KIND_W'($urandom_range(9, 15));  // unused codes
        // half of the indices land just below the search limit
        if (lim > 0 && $urandom_range(0, 1))
          idx = INDEX_W'($urandom_range((lim > 128) ? lim - 128 : 0, lim - 1));
        else
          idx = INDEX_W'($urandom);
        queue_op(op, idx);
        done_cnt++;
      end
    end
  endtask

  initial begin
    int unsigned size_plan[9];
    logic [SIZE_W-1:0] next_size;

    size_plan = '{0, 1, 2047, 1025, 63, 64, 1023, 1024, 512};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset size, empty bitmap, both ends of the index range,
    // every kind including unused ones, scans with and without a match.
    queue_op(K_FIND_SET,    10'd0);     // empty bitmap: nothing found
    queue_op(K_FIND_ZERO,   10'd1023);
    queue_op(K_SET,         10'd0);
    queue_op(K_SET,         10'd1023);
    queue_op(K_TEST,        10'd1023);
    queue_op(K_FIND_SET,    10'd1);     // walks every word to the top bit
    queue_op(K_FIND_ZERO,   10'd0);
    queue_op(K_TEST_SET,    10'd0);
    queue_op(K_CLEAR,       10'd0);
    queue_op(K_TEST_CLEAR,  10'd0);
    queue_op(K_TOGGLE,      10'd64);
    queue_op(K_TEST_TOGGLE, 10'd64);
    queue_op(K_TEST_TOGGLE, 10'd64);
    queue_op(K_FIND_SET,    10'd1);
    queue_op(K_FIND_SET,    10'd65);
    queue_op(K_FIND_ZERO,   10'd1023);  // top bit set: no zero below the size
    queue_op(K_TEST,        10'd64);
    queue_op(KIND_W'(9),    10'd64);
    queue_op(KIND_W'(15),   10'd1023);
    queue_op(K_FIND_SET,    10'd1023);
    queue_op(K_TEST_CLEAR,  10'd1023);
    queue_op(K_FIND_SET,    10'd1000);
    wait_drained();

    // Random phases, each under a fresh size. Sizes cover zero, one, word
    // edges, the full bitmap and values above it that saturate.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 9)       next_size = SIZE_W'(size_plan[p]);
      else if (p == 9) next_size = SIZE_W'($urandom_range(1, BITMAP_BITS));
      else             next_size = SIZE_W'($urandom_range(0, 2047));
      case (p % 4)
        0: begin send_gap_max = 0;  recv_gap_max = 0;  end
        1: begin send_gap_max = 10; recv_gap_max = 10; end
        2: begin send_gap_max = 0;  recv_gap_max = 10; end
        default: begin send_gap_max = 10; recv_gap_max = 0; end
      endcase
      write_size(next_size);
      queue_random_phase(PHASE_ITEMS);
      // back-to-back sender while the receiver holds off fills the block
      if (p == 2) hold_asks++;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== bitmap_bit_ops_find_next_top.f =====
+incdir+rtl
rtl/bbf_pkg.sv
rtl/bbf_datapath.sv
rtl/bbf_ctrl.sv
rtl/bitmap_bit_ops_find_next_top.sv
tb/tb_top.sv
